// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only.
`define FPR_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("firmware_packet_receiver: assertion failed");

// Property checked at every edge, reset included.
`define FPR_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("firmware_packet_receiver: assertion failed");

`endif

// ----- rtl/core/fpr_pkg.sv -----
`default_nettype none
package fpr_pkg;

   localparam int unsigned CHUNK_MAX = 256;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] ACK_BYTE   = 8'h79;
   localparam logic [7:0] NACK_BYTE  = 8'h1F;

   localparam logic [15:0] CHUNK_MAX_LEN = 16'(CHUNK_MAX);
   localparam logic [15:0] TICK_SATURATE = 16'hFFFF;

   localparam logic [31:0] IMAGE_BASE_RESET    = 32'd0;
   localparam logic [20:0] IMAGE_LIMIT_RESET   = 21'd131072;
   localparam logic [15:0] START_TIMEOUT_RESET = 16'd3000;
   localparam logic [15:0] BYTE_TIMEOUT_RESET  = 16'd1000;

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_SESSION = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      CSR_IMAGE_BASE    = 2'd0,
      CSR_IMAGE_LIMIT   = 2'd1,
      CSR_START_TIMEOUT = 2'd2,
      CSR_BYTE_TIMEOUT  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ERASE   = 2'd1,
      KIND_COMMIT  = 2'd2,
      KIND_REPLY   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_UPDATE = 3'd1,
      ST_BAD_FRAME = 3'd2,
      ST_TIMEOUT   = 3'd3,
      ST_TOO_LARGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_START   = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CK_HI   = 3'd5,
      PH_CK_LO   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [31:0] image_base;
      logic [20:0] image_limit;
      logic [15:0] start_timeout_ms;
      logic [15:0] byte_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [31:0] address;
      logic [8:0]  chunk_length;
      logic [2:0]  status;
      logic        session_end;
   } rsp_rec_type;

   // Up to three results caused by one request, in order from rec[0].
   typedef struct packed {
      logic [1:0]             count;
      rsp_rec_type [2:0]      rec;
   } rsp_group_type;

endpackage
`default_nettype wire

// ----- rtl/core/fpr_proto.sv -----
`default_nettype none
module fpr_proto (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [1:0]            command,
   input  wire logic [7:0]            rx_byte,
   input  wire fpr_pkg::cfg_type      cfg,
   output fpr_pkg::rsp_group_type     group
);
   import fpr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        first_ff, first_in;
   logic [15:0] plen_ff, plen_in;
   logic [8:0]  idx_ff, idx_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  chb_ff, chb_in;
   logic [20:0] written_ff, written_in;
   logic [15:0] tc_ff, tc_in;

   logic        tick_arm;
   logic        tick_expire;
   logic [15:0] tc_inc;
   logic [15:0] tick_limit;
   status_type  tick_status;
   logic [15:0] len_full;
   logic [15:0] sum_next;
   logic [8:0]  idx_next;
   logic        ck_ok;
   logic        too_large;
   logic [21:0] total;
   logic [31:0] pay_addr;
   logic [31:0] commit_addr;

   function automatic rsp_rec_type mk_rec(kind_type k, logic [7:0] v, logic [31:0] a,
                                          logic [8:0] l, status_type s, logic e);
      rsp_rec_type r;
      r.kind         = k;
      r.byte_value   = v;
      r.address      = a;
      r.chunk_length = l;
      r.status       = s;
      r.session_end  = e;
      return r;
   endfunction

   // The start timeout only runs while waiting for the first packet of a session.
   assign tick_arm = (phase_ff == PH_START && first_ff) || phase_ff == PH_LEN_HI ||
                     phase_ff == PH_LEN_LO || phase_ff == PH_PAYLOAD ||
                     phase_ff == PH_CK_HI || phase_ff == PH_CK_LO;
   assign tc_inc      = (tc_ff == TICK_SATURATE) ? tc_ff : tc_ff + 16'd1;
   assign tick_limit  = (phase_ff == PH_START) ? cfg.start_timeout_ms : cfg.byte_timeout_ms;
   assign tick_status = (phase_ff == PH_START) ? ST_NO_UPDATE : ST_TIMEOUT;
   assign tick_expire = tick_arm && (tc_inc >= tick_limit);

   assign len_full    = {plen_ff[15:8], rx_byte};
   assign sum_next    = sum_ff + {8'd0, rx_byte};
   assign idx_next    = idx_ff + 9'd1;
   assign ck_ok       = ({chb_ff, rx_byte} == sum_ff);
   assign total       = {1'b0, written_ff} + {6'd0, plen_ff};
   assign too_large   = total > {1'b0, cfg.image_limit};
   assign commit_addr = cfg.image_base + {11'd0, written_ff};
   assign pay_addr    = commit_addr + {23'd0, idx_ff};

   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      plen_in    = plen_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      chb_in     = chb_ff;
      written_in = written_ff;
      tc_in      = tc_ff;
      if (step) begin
         unique case (command)
            CMD_BYTE: begin
               unique case (phase_ff)
                  PH_START: begin
                     if (rx_byte != START_BYTE) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_LEN_HI;
                        tc_in    = 16'd0;
                     end
                  end
                  PH_LEN_HI: begin
                     plen_in  = {rx_byte, 8'd0};
                     phase_in = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     plen_in = len_full;
                     if (len_full > CHUNK_MAX_LEN || len_full == 16'd0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        idx_in   = 9'd0;
                        sum_in   = 16'd0;
                        tc_in    = 16'd0;
                        phase_in = PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     sum_in = sum_next;
                     idx_in = idx_next;
                     if ({7'd0, idx_next} >= plen_ff) begin
                        phase_in = PH_CK_HI;
                        tc_in    = 16'd0;
                     end
                  end
                  PH_CK_HI: begin
                     chb_in   = rx_byte;
                     phase_in = PH_CK_LO;
                  end
                  PH_CK_LO: begin
                     if (!ck_ok || too_large) begin
                        phase_in = PH_IDLE;
                     end else begin
                        written_in = total[20:0];
                        first_in   = 1'b0;
                        phase_in   = PH_START;
                        tc_in      = 16'd0;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_TICK: begin
               if (tick_arm) begin
                  tc_in = tc_inc;
                  if (tick_expire) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            CMD_SESSION: begin
               phase_in   = PH_START;
               first_in   = 1'b1;
               plen_in    = 16'd0;
               idx_in     = 9'd0;
               sum_in     = 16'd0;
               chb_in     = 8'd0;
               written_in = 21'd0;
               tc_in      = 16'd0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      group = '0;
      unique case (command)
         CMD_BYTE: begin
            unique case (phase_ff)
               PH_START: begin
                  if (rx_byte != START_BYTE) begin
                     group.count  = 2'd1;
                     group.rec[0] = mk_rec(KIND_REPLY, NACK_BYTE, '0, '0, ST_BAD_FRAME, 1'b1);
                  end
               end
               PH_LEN_LO: begin
                  if (len_full > CHUNK_MAX_LEN) begin
                     group.count  = 2'd1;
                     group.rec[0] = mk_rec(KIND_REPLY, NACK_BYTE, '0, '0, ST_TOO_LARGE, 1'b1);
                  end else if (len_full == 16'd0) begin
                     group.count  = 2'd1;
                     group.rec[0] = mk_rec(KIND_REPLY, ACK_BYTE, '0, '0,
                                           first_ff ? ST_NO_UPDATE : ST_OK, 1'b1);
                  end
               end
               PH_PAYLOAD: begin
                  group.count  = 2'd1;
                  group.rec[0] = mk_rec(KIND_PAYLOAD, rx_byte, pay_addr, '0, ST_OK, 1'b0);
               end
               PH_CK_LO: begin
                  if (!ck_ok) begin
                     group.count  = 2'd1;
                     group.rec[0] = mk_rec(KIND_REPLY, NACK_BYTE, '0, '0, ST_BAD_FRAME, 1'b1);
                  end else if (first_ff) begin
                     group.rec[0] = mk_rec(KIND_ERASE, '0, cfg.image_base, '0, ST_OK, 1'b0);
                     if (too_large) begin
                        group.count  = 2'd2;
                        group.rec[1] = mk_rec(KIND_REPLY, NACK_BYTE, '0, '0, ST_TOO_LARGE,
                                              1'b1);
                     end else begin
                        group.count  = 2'd3;
                        group.rec[1] = mk_rec(KIND_COMMIT, '0, commit_addr, plen_ff[8:0],
                                              ST_OK, 1'b0);
                        group.rec[2] = mk_rec(KIND_REPLY, ACK_BYTE, '0, '0, ST_OK, 1'b0);
                     end
                  end else if (too_large) begin
                     group.count  = 2'd1;
                     group.rec[0] = mk_rec(KIND_REPLY, NACK_BYTE, '0, '0, ST_TOO_LARGE, 1'b1);
                  end else begin
                     group.count  = 2'd2;
                     group.rec[0] = mk_rec(KIND_COMMIT, '0, commit_addr, plen_ff[8:0],
                                           ST_OK, 1'b0);
                     group.rec[1] = mk_rec(KIND_REPLY, ACK_BYTE, '0, '0, ST_OK, 1'b0);
                  end
               end
               default: ;
            endcase
         end
         CMD_TICK: begin
            if (tick_expire) begin
               group.count  = 2'd1;
               group.rec[0] = mk_rec(KIND_REPLY, NACK_BYTE, '0, '0, tick_status, 1'b1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         first_ff   <= 1'b1;
         plen_ff    <= '0;
         idx_ff     <= '0;
         sum_ff     <= '0;
         chb_ff     <= '0;
         written_ff <= '0;
         tc_ff      <= '0;
      end else begin
         phase_ff   <= phase_in;
         first_ff   <= first_in;
         plen_ff    <= plen_in;
         idx_ff     <= idx_in;
         sum_ff     <= sum_in;
         chb_ff     <= chb_in;
         written_ff <= written_in;
         tc_ff      <= tc_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/fpr_outq.sv -----
`default_nettype none
module fpr_outq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire fpr_pkg::rsp_group_type group,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output fpr_pkg::rsp_rec_type       rsp_rec,
   output logic                       rsp_last
);
   import fpr_pkg::*;

   rsp_group_type grp_ff;
   logic [1:0]    left_ff, left_in;
   logic [1:0]    pos_ff, pos_in;

   assign rsp_valid = (left_ff != 2'd0);
   assign rsp_last  = (left_ff == 2'd1);
   // A new group may replace the last result in the very cycle it is taken.
   assign can_load  = !rsp_valid || (rsp_last && rsp_ready);

   always_comb begin
      unique case (pos_ff)
         2'd1:    rsp_rec = grp_ff.rec[1];
         2'd2:    rsp_rec = grp_ff.rec[2];
         default: rsp_rec = grp_ff.rec[0];
      endcase
   end

   always_comb begin
      left_in = left_ff;
      pos_in  = pos_ff;
      if (load && can_load) begin
         left_in = group.count;
         pos_in  = 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         left_in = left_ff - 2'd1;
         pos_in  = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         pos_ff  <= '0;
      end else begin
         left_ff <= left_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && can_load) begin
         grp_ff <= group;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/firmware_packet_receiver.sv -----
// Pipeline: a request enters the input register at acceptance; its results are worked out
// from that register and loaded into the result register, from which the first is offered on rsp_.
// Throughput: one request per cycle while each yields at most one result and rsp_ready is high;
// a request with several results holds the result register until each is taken in turn on the
// single result port. Reset is synchronous: it empties both registers, idles the protocol and
// restores the configuration registers to their defaults.
`default_nettype none
`include "assert_macros.svh"
module firmware_packet_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte_value,
   output logic [31:0]      rsp_address,
   output logic [8:0]       rsp_chunk_length,
   output logic [2:0]       rsp_status,
   output logic             rsp_session_end,
   output logic             rsp_last
);
   import fpr_pkg::*;

   cfg_type       cfg_ff;
   logic          in_vld_ff;
   logic [1:0]    in_cmd_ff;
   logic [7:0]    in_byte_ff;
   logic          advance;
   logic          grp_load;
   logic          can_load;
   rsp_group_type group;
   rsp_rec_type   rsp_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_base       <= IMAGE_BASE_RESET;
         cfg_ff.image_limit      <= IMAGE_LIMIT_RESET;
         cfg_ff.start_timeout_ms <= START_TIMEOUT_RESET;
         cfg_ff.byte_timeout_ms  <= BYTE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_BASE:    cfg_ff.image_base       <= csr_wdata;
            CSR_IMAGE_LIMIT:   cfg_ff.image_limit      <= csr_wdata[20:0];
            CSR_START_TIMEOUT: cfg_ff.start_timeout_ms <= csr_wdata[15:0];
            CSR_BYTE_TIMEOUT:  cfg_ff.byte_timeout_ms  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // A request with no results never waits on the result register.
   assign advance   = in_vld_ff && (group.count == 2'd0 || can_load);
   assign grp_load  = advance && (group.count != 2'd0);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_rx_byte;
      end
   end

   fpr_proto u_proto (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .command (in_cmd_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .group   (group)
   );

   fpr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (grp_load),
      .group     (group),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_rec   (rsp_rec),
      .rsp_last  (rsp_last)
   );

   assign rsp_kind         = rsp_rec.kind;
   assign rsp_byte_value   = rsp_rec.byte_value;
   assign rsp_address      = rsp_rec.address;
   assign rsp_chunk_length = rsp_rec.chunk_length;
   assign rsp_status       = rsp_rec.status;
   assign rsp_session_end  = rsp_rec.session_end;

   `FPR_ASSERT(a_group_shown, grp_load |=> rsp_valid)
   `FPR_ASSERT(a_end_last, rsp_valid && rsp_session_end |-> rsp_last && rsp_kind == KIND_REPLY)
   `FPR_ASSERT(a_last_drains, (rsp_valid && rsp_last && rsp_ready && !grp_load) |=> !rsp_valid)
   `FPR_ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_valid && !in_vld_ff))

endmodule
`default_nettype wire
